/* rtl/obb_pkg.sv */
// obb_pkg: shared types, constants and rounding helpers of the oriented-box
// overlap tester. No dependencies; used by every module of the block.
package obb_pkg;

  localparam int unsigned CoordW    = 32;   // Q16.16 centre
  localparam int unsigned HalfW     = 31;   // Q16.16 half-extent
  localparam int unsigned QuatW     = 16;   // Q2.14
  localparam int unsigned EpsW      = 11;
  localparam int unsigned ArW       = 17;   // |R| + epsilon
  localparam int unsigned TW        = 33;   // centre difference
  localparam int unsigned TaW       = 38;   // projected translation
  localparam int unsigned OpAW      = 38;
  localparam int unsigned OpBW      = 18;
  localparam int unsigned ProdW     = OpAW + OpBW;
  localparam int unsigned SumW      = 60;
  localparam int unsigned Lanes     = 4;
  localparam int unsigned InTdataW  = 256;
  localparam int unsigned OutTdataW = 8;

  localparam logic [EpsW-1:0]        EpsReset = 11'd2;
  localparam logic signed [QuatW-1:0] OneQ14  = 16'sd16384;
  localparam logic signed [SumW-1:0]  OneQ28  = 60'sd268435456;
  localparam logic signed [SumW-1:0]  RndHalf = 60'sd8192;
  localparam logic signed [SumW-1:0]  SatHi   = 60'sd32767;
  localparam logic signed [SumW-1:0]  SatLo   = -60'sd32768;
  localparam int unsigned             FracQ14 = 14;
  localparam logic [1:0]              LastIdx = 2'd2;
  localparam logic                    KindLoad = 1'b0;

  // cyclic axis order {a0, a1, a2} for each leading axis
  localparam logic [1:0] AxisRot [3][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1}
  };

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [QuatW-1:0]  q14_t;
  typedef logic [HalfW-1:0]         half_t;

  typedef struct packed {
    logic             kind;
    coord_t [2:0]     center;
    half_t  [2:0]     half;
    q14_t   [3:0]     quat;     // w, x, y, z at 0..3
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } st_e;

  typedef enum logic [2:0] {
    PH_AXES,
    PH_ROT,
    PH_TRANS,
    PH_FACEA,
    PH_FACEB,
    PH_CROSS
  } ph_e;

  // Q4.28 sum to Q2.14, round half up, saturate to 16 bits
  function automatic q14_t rnd_sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] t;
    t = (v + RndHalf) >>> FracQ14;
    if (t > SatHi) begin
      t = SatHi;
    end else if (t < SatLo) begin
      t = SatLo;
    end
    return t[QuatW-1:0];
  endfunction

endpackage

/* rtl/obb_front.sv */
// obb_front: input side. Accepts box transactions, unpacks the fields and
// queues them for the back end. Depends on obb_pkg.
module obb_front #(
  parameter int unsigned QDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
  input  logic [obb_pkg::InTdataW-1:0]  s_axis_tdata,
  // kind
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          pop_i,
  output logic                          avail_o,
  output obb_pkg::item_t                item_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

  obb_pkg::item_t  in_item;
  obb_pkg::item_t  fifo_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  always_comb begin
    in_item.kind      = s_axis_tuser[0];
    in_item.center[0] = s_axis_tdata[31:0];
    in_item.center[1] = s_axis_tdata[63:32];
    in_item.center[2] = s_axis_tdata[95:64];
    in_item.half[0]   = s_axis_tdata[126:96];
    in_item.half[1]   = s_axis_tdata[157:127];
    in_item.half[2]   = s_axis_tdata[188:158];
    in_item.quat[0]   = s_axis_tdata[204:189];
    in_item.quat[1]   = s_axis_tdata[220:205];
    in_item.quat[2]   = s_axis_tdata[236:221];
    in_item.quat[3]   = s_axis_tdata[252:237];
  end

  assign s_axis_tready = (cnt_q != CntFull);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign avail_o       = (cnt_q != '0);
  assign pop           = pop_i && avail_o;
  assign item_o        = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

/* rtl/obb_back.sv */
// obb_back: sequencer and shared four-lane multiply unit that runs the
// separating-axis test, plus the result register. Depends on obb_pkg.
module obb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [obb_pkg::EpsW-1:0]       cfg_wdata_i,
  input  logic                           avail_i,
  input  obb_pkg::item_t                 item_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // overlaps at bit 0, zero padded
  output logic [obb_pkg::OutTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned SumW = obb_pkg::SumW;

  obb_pkg::st_e st_q, st_d;
  obb_pkg::ph_e ph_q, ph_d;
  logic [1:0]   i_q, i_d, j_q, j_d;
  logic         sub_q, sub_d;

  logic                       load_q;
  logic [obb_pkg::EpsW-1:0]   eps_q;
  obb_pkg::q14_t              q_q  [4];
  obb_pkg::q14_t              aa_q [3][3];
  obb_pkg::q14_t              ba_q [3][3];
  obb_pkg::q14_t              r_q  [3][3];
  logic [obb_pkg::ArW-1:0]    ar_q [3][3];
  obb_pkg::coord_t            rc_q [3];
  obb_pkg::half_t             rh_q [3];
  obb_pkg::half_t             bh_q [3];
  logic signed [obb_pkg::TW-1:0]    t_q  [3];
  logic signed [obb_pkg::TaW-1:0]   ta_q [3];
  logic signed [obb_pkg::ProdW-1:0] prod_q [obb_pkg::Lanes];
  logic signed [SumW-1:0]     lhs_q;
  logic                       sep_q;
  logic                       out_valid_q, out_q;

  logic signed [obb_pkg::OpAW-1:0] opa [obb_pkg::Lanes];
  logic signed [obb_pkg::OpBW-1:0] opb [obb_pkg::Lanes];
  logic signed [SumW-1:0]          kconst, sum, sum_abs;
  obb_pkg::q14_t                   rs;
  logic signed [obb_pkg::ArW-1:0]  rs_x, rs_abs;
  logic [obb_pkg::ArW-1:0]         ar_new;
  logic                            start, emit;

  // ---------------------------------------------------------------- operands
  always_comb begin
    logic signed [obb_pkg::OpAW-1:0] w2, x2, y2, z2;
    logic [1:0] a0, a1, a2, b1, b2;
    w2 = obb_pkg::OpAW'(q_q[0]) <<< 1;
    x2 = obb_pkg::OpAW'(q_q[1]) <<< 1;
    y2 = obb_pkg::OpAW'(q_q[2]) <<< 1;
    z2 = obb_pkg::OpAW'(q_q[3]) <<< 1;
    a0 = obb_pkg::AxisRot[i_q][0];
    a1 = obb_pkg::AxisRot[i_q][1];
    a2 = obb_pkg::AxisRot[i_q][2];
    b1 = obb_pkg::AxisRot[j_q][1];
    b2 = obb_pkg::AxisRot[j_q][2];
    kconst = '0;
    for (int l = 0; l < obb_pkg::Lanes; l++) begin
      opa[l] = '0;
      opb[l] = '0;
    end
    unique case (ph_q)
      obb_pkg::PH_AXES: begin
        // entry j of local axis i from the quaternion
        case ({i_q, j_q})
          4'b0000: begin
            opa[0] = -y2; opb[0] = obb_pkg::OpBW'(q_q[2]);
            opa[1] = -z2; opb[1] = obb_pkg::OpBW'(q_q[3]);
            kconst = obb_pkg::OneQ28;
          end
          4'b0001: begin
            opa[0] = x2;  opb[0] = obb_pkg::OpBW'(q_q[2]);
            opa[1] = w2;  opb[1] = obb_pkg::OpBW'(q_q[3]);
          end
          4'b0010: begin
            opa[0] = x2;  opb[0] = obb_pkg::OpBW'(q_q[3]);
            opa[1] = -w2; opb[1] = obb_pkg::OpBW'(q_q[2]);
          end
          4'b0100: begin
            opa[0] = x2;  opb[0] = obb_pkg::OpBW'(q_q[2]);
            opa[1] = -w2; opb[1] = obb_pkg::OpBW'(q_q[3]);
          end
          4'b0101: begin
            opa[0] = -x2; opb[0] = obb_pkg::OpBW'(q_q[1]);
            opa[1] = -z2; opb[1] = obb_pkg::OpBW'(q_q[3]);
            kconst = obb_pkg::OneQ28;
          end
          4'b0110: begin
            opa[0] = y2;  opb[0] = obb_pkg::OpBW'(q_q[3]);
            opa[1] = w2;  opb[1] = obb_pkg::OpBW'(q_q[1]);
          end
          4'b1000: begin
            opa[0] = x2;  opb[0] = obb_pkg::OpBW'(q_q[3]);
            opa[1] = w2;  opb[1] = obb_pkg::OpBW'(q_q[2]);
          end
          4'b1001: begin
            opa[0] = y2;  opb[0] = obb_pkg::OpBW'(q_q[3]);
            opa[1] = -w2; opb[1] = obb_pkg::OpBW'(q_q[1]);
          end
          4'b1010: begin
            opa[0] = -x2; opb[0] = obb_pkg::OpBW'(q_q[1]);
            opa[1] = -y2; opb[1] = obb_pkg::OpBW'(q_q[2]);
            kconst = obb_pkg::OneQ28;
          end
          default: begin
            kconst = '0;
          end
        endcase
      end
      obb_pkg::PH_ROT: begin
        for (int c = 0; c < 3; c++) begin
          opa[c] = obb_pkg::OpAW'(aa_q[i_q][c]);
          opb[c] = obb_pkg::OpBW'(ba_q[j_q][c]);
        end
      end
      obb_pkg::PH_TRANS: begin
        for (int c = 0; c < 3; c++) begin
          opa[c] = obb_pkg::OpAW'(t_q[c]);
          opb[c] = obb_pkg::OpBW'(aa_q[i_q][c]);
        end
      end
      obb_pkg::PH_FACEA: begin
        if (!sub_q) begin
          opa[0] = obb_pkg::OpAW'(ta_q[i_q]);
          opb[0] = obb_pkg::OpBW'(obb_pkg::OneQ14);
        end else begin
          opa[3] = obb_pkg::OpAW'(rh_q[i_q]);
          opb[3] = obb_pkg::OpBW'(obb_pkg::OneQ14);
          for (int c = 0; c < 3; c++) begin
            opa[c] = obb_pkg::OpAW'(bh_q[c]);
            opb[c] = obb_pkg::OpBW'(ar_q[i_q][c]);
          end
        end
      end
      obb_pkg::PH_FACEB: begin
        if (!sub_q) begin
          for (int c = 0; c < 3; c++) begin
            opa[c] = obb_pkg::OpAW'(ta_q[c]);
            opb[c] = obb_pkg::OpBW'(r_q[c][i_q]);
          end
        end else begin
          opa[3] = obb_pkg::OpAW'(bh_q[i_q]);
          opb[3] = obb_pkg::OpBW'(obb_pkg::OneQ14);
          for (int c = 0; c < 3; c++) begin
            opa[c] = obb_pkg::OpAW'(rh_q[c]);
            opb[c] = obb_pkg::OpBW'(ar_q[c][i_q]);
          end
        end
      end
      obb_pkg::PH_CROSS: begin
        if (!sub_q) begin
          opa[0] = obb_pkg::OpAW'(ta_q[a2]);
          opb[0] = obb_pkg::OpBW'(r_q[a1][j_q]);
          opa[1] = -obb_pkg::OpAW'(ta_q[a1]);
          opb[1] = obb_pkg::OpBW'(r_q[a2][j_q]);
        end else begin
          opa[0] = obb_pkg::OpAW'(rh_q[a1]); opb[0] = obb_pkg::OpBW'(ar_q[a2][j_q]);
          opa[1] = obb_pkg::OpAW'(rh_q[a2]); opb[1] = obb_pkg::OpBW'(ar_q[a1][j_q]);
          opa[2] = obb_pkg::OpAW'(bh_q[b1]); opb[2] = obb_pkg::OpBW'(ar_q[a0][b2]);
          opa[3] = obb_pkg::OpAW'(bh_q[b2]); opb[3] = obb_pkg::OpBW'(ar_q[a0][b1]);
        end
      end
      default: begin
        kconst = '0;
      end
    endcase
  end

  // ------------------------------------------------------------ accumulate
  always_comb begin
    sum = kconst;
    for (int l = 0; l < obb_pkg::Lanes; l++) begin
      sum = sum + SumW'(prod_q[l]);
    end
    sum_abs = (sum < 0) ? -sum : sum;
    rs      = obb_pkg::rnd_sat(sum);
    rs_x    = obb_pkg::ArW'(rs);
    rs_abs  = (rs_x < 0) ? -rs_x : rs_x;
    ar_new  = obb_pkg::ArW'(rs_abs) + obb_pkg::ArW'(eps_q);
  end

  // ---------------------------------------------------------- next state
  always_comb begin
    st_d  = st_q;
    ph_d  = ph_q;
    i_d   = i_q;
    j_d   = j_q;
    sub_d = sub_q;
    unique case (st_q)
      obb_pkg::ST_IDLE: begin
        if (avail_i) begin
          st_d  = obb_pkg::ST_MUL;
          ph_d  = obb_pkg::PH_AXES;
          i_d   = '0;
          j_d   = '0;
          sub_d = 1'b0;
        end
      end
      obb_pkg::ST_MUL: begin
        st_d = obb_pkg::ST_ACC;
      end
      obb_pkg::ST_ACC: begin
        st_d = obb_pkg::ST_MUL;
        unique case (ph_q) inside
          obb_pkg::PH_AXES, obb_pkg::PH_ROT: begin
            if (j_q == obb_pkg::LastIdx) begin
              j_d = '0;
              if (i_q == obb_pkg::LastIdx) begin
                i_d = '0;
                if (ph_q == obb_pkg::PH_AXES && load_q) begin
                  st_d = obb_pkg::ST_IDLE;
                end else if (ph_q == obb_pkg::PH_AXES) begin
                  ph_d = obb_pkg::PH_ROT;
                end else begin
                  ph_d = obb_pkg::PH_TRANS;
                end
              end else begin
                i_d = i_q + 2'd1;
              end
            end else begin
              j_d = j_q + 2'd1;
            end
          end
          obb_pkg::PH_TRANS: begin
            if (i_q == obb_pkg::LastIdx) begin
              i_d  = '0;
              ph_d = obb_pkg::PH_FACEA;
            end else begin
              i_d = i_q + 2'd1;
            end
          end
          obb_pkg::PH_FACEA, obb_pkg::PH_FACEB: begin
            sub_d = !sub_q;
            if (sub_q) begin
              if (i_q == obb_pkg::LastIdx) begin
                i_d  = '0;
                j_d  = '0;
                ph_d = (ph_q == obb_pkg::PH_FACEA) ? obb_pkg::PH_FACEB
                                                   : obb_pkg::PH_CROSS;
              end else begin
                i_d = i_q + 2'd1;
              end
            end
          end
          obb_pkg::PH_CROSS: begin
            sub_d = !sub_q;
            if (sub_q) begin
              if (j_q == obb_pkg::LastIdx) begin
                j_d = '0;
                if (i_q == obb_pkg::LastIdx) begin
                  st_d = obb_pkg::ST_DONE;
                end else begin
                  i_d = i_q + 2'd1;
                end
              end else begin
                j_d = j_q + 2'd1;
              end
            end
          end
          default: begin
            st_d = obb_pkg::ST_IDLE;
          end
        endcase
      end
      obb_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          st_d = obb_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = obb_pkg::ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------- outputs
  always_comb begin
    start         = (st_q == obb_pkg::ST_IDLE) && avail_i;
    emit          = (st_q == obb_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
    pop_o         = start;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = obb_pkg::OutTdataW'(out_q);
  end

  // ------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= obb_pkg::ST_IDLE;
      ph_q        <= obb_pkg::PH_AXES;
      i_q         <= '0;
      j_q         <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
      eps_q       <= obb_pkg::EpsReset;
      for (int a = 0; a < 3; a++) begin
        rc_q[a] <= '0;
        rh_q[a] <= '0;
        for (int b = 0; b < 3; b++) begin
          aa_q[a][b] <= (a == b) ? obb_pkg::OneQ14 : '0;
        end
      end
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      i_q   <= i_d;
      j_q   <= j_d;
      sub_q <= sub_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (start && item_i.kind == obb_pkg::KindLoad) begin
        for (int a = 0; a < 3; a++) begin
          rc_q[a] <= item_i.center[a];
          rh_q[a] <= item_i.half[a];
        end
      end
      // reference axes are kept instead of its quaternion
      if (st_q == obb_pkg::ST_ACC && ph_q == obb_pkg::PH_AXES && load_q) begin
        aa_q[i_q][j_q] <= rs;
      end
    end
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (start) begin
      load_q <= (item_i.kind == obb_pkg::KindLoad);
      sep_q  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        q_q[k] <= item_i.quat[k];
      end
      for (int k = 0; k < 3; k++) begin
        bh_q[k] <= item_i.half[k];
        t_q[k]  <= obb_pkg::TW'(item_i.center[k]) - obb_pkg::TW'(rc_q[k]);
      end
    end
    if (st_q == obb_pkg::ST_MUL) begin
      for (int l = 0; l < obb_pkg::Lanes; l++) begin
        prod_q[l] <= opa[l] * opb[l];
      end
    end
    if (st_q == obb_pkg::ST_ACC) begin
      case (ph_q)
        obb_pkg::PH_AXES: begin
          if (!load_q) begin
            ba_q[i_q][j_q] <= rs;
          end
        end
        obb_pkg::PH_ROT: begin
          r_q[i_q][j_q]  <= rs;
          ar_q[i_q][j_q] <= ar_new;
        end
        obb_pkg::PH_TRANS: begin
          ta_q[i_q] <= obb_pkg::TaW'((sum + obb_pkg::RndHalf) >>> obb_pkg::FracQ14);
        end
        default: begin
          // projection first, then radius sum and compare
          if (!sub_q) begin
            lhs_q <= sum_abs;
          end else if (lhs_q > sum) begin
            sep_q <= 1'b1;
          end
        end
      endcase
    end
    if (emit) begin
      out_q <= !sep_q;
    end
  end

endmodule

/* rtl/obb_overlap_test.sv */
// obb_overlap_test: top level of the oriented-box overlap tester.
// Instantiates obb_front (input queue) and obb_back (sequencer); uses obb_pkg.
//
// Usage:
//   s_axis carries one box per transaction: centre and half-extents in
//   Q16.16, orientation quaternion in Q2.14; tuser is the kind. Kind 0
//   replaces the reference box and returns nothing; kind 1 is tested
//   against the reference and returns one transaction on m_axis with the
//   overlap flag in tdata bit 0.
//   cfg_we_i writes abs_epsilon from cfg_wdata_i; write it only when idle.
// Sequencing:
//   One shared four-lane multiply unit does every product; each step is a
//   multiply, then a sum and write back. A load takes 9 axis steps; a test
//   takes 9 axis, 9 rotation, 3 translation and 30 test steps.
//   The input queue holds QDepth boxes; s_axis_tready drops once it is
//   full and rises again when the back end takes the next box.
//   If m_axis is stalled the result holds in the output register and
//   the next result waits in the back end until it is taken.
// Reset: queue empty, no result pending, reference box a point at the
//   origin with identity orientation, abs_epsilon 2.
module obb_overlap_test #(
  parameter int unsigned QDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
  input  logic [obb_pkg::InTdataW-1:0]  s_axis_tdata,
  // kind
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // overlaps at bit 0, zero padded
  output logic [obb_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [obb_pkg::EpsW-1:0]      cfg_wdata_i
);

  obb_pkg::item_t item;
  logic           avail, pop;

  obb_front #(
    .QDepth(QDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .avail_o       (avail),
    .item_o        (item)
  );

  obb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .avail_i       (avail),
    .item_i        (item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/obb_checker.sv */
// obb_checker: port-level assertions for obb_overlap_test, bound to the top.
// Depends on obb_pkg for port widths.
module obb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [obb_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic [0:0]                    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [obb_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          cfg_we_i,
  input logic [obb_pkg::EpsW-1:0]      cfg_wdata_i
);

  logic [7:0] pend_q;
  logic       test_in, res_out;

  assign test_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] != obb_pkg::KindLoad);
  assign res_out = m_axis_tvalid && m_axis_tready;

  // tests accepted whose results are not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (test_in && !res_out) begin
      pend_q <= pend_q + 8'd1;
    end else if (res_out && !test_in) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 8'd0)
    else $error("result without a pending test transaction");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[obb_pkg::OutTdataW-1:1] == '0)
    else $error("result padding not zero");

  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

  // offered transactions and register writes carry known values
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid |-> !$isunknown({s_axis_tuser, s_axis_tdata})) and
    (cfg_we_i |-> !$isunknown(cfg_wdata_i)))
    else $error("input transaction or configuration write with unknown data");

endmodule

bind obb_overlap_test obb_checker u_obb_checker (.*);
